/* hw/rtl/edbw_pkg.sv */
`default_nettype none

package edbw_pkg;

    localparam int BUFFER_BYTES = 32;
    localparam int CHECK_INDEX  = 31;
    localparam int MAX_RESULTS  = 32;

    localparam int IDX_W  = $clog2(BUFFER_BYTES);
    localparam int CNT_W  = $clog2(MAX_RESULTS + 1);
    localparam int LOC_W  = 5;
    localparam int BASE_W = 12;
    localparam int ADDR_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic HAS_CHECK = (CHECK_INDEX < BUFFER_BYTES);

    typedef logic [7:0] t_byte;
    typedef logic [IDX_W-1:0] t_idx;

    typedef enum logic {
        FUNC_SAVE  = 1'b0,
        FUNC_FLUSH = 1'b1
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHECK_ENABLE = 2'd0,
        CFG_WRITE_ALL    = 2'd1,
        CFG_BASE_ADDRESS = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic              check_enable;
        logic              write_all;
        logic [BASE_W-1:0] base_address;
    } t_cfg;

    typedef struct packed {
        logic  rd_en;
        logic  wr_en;
        t_idx  addr;
        t_byte wdata;
    } t_ram_req;

endpackage

`default_nettype wire

/* hw/rtl/eeprom_dirty_byte_write_back.sv */
// Save: request taken with a read of the shadow RAM, then, once the output register is
//   free, the byte is written back and the acknowledge registered; input stalls till idle.
// Flush: the check byte is written first (if enabled), then every buffer slot is scanned
//   and each selected byte is read from RAM and then sent; nothing to do gives an ack.
// Reset (synchronous): check on, write-all off, base 0, no dirty bytes; shadow bytes
//   read as zero until written, so no clearing pass is needed.
`default_nettype none

module eeprom_dirty_byte_write_back (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [edbw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [edbw_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire                                i_func,
    input  wire [edbw_pkg::LOC_W-1:0]          i_loc,
    input  wire [7:0]                          i_dat,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic                               o_write_valid,
    output logic [edbw_pkg::ADDR_W-1:0]        o_write_address,
    output logic [7:0]                         o_write_data,
    output logic                               o_last
);

    edbw_pkg::t_cfg     r_cfg;
    edbw_pkg::t_ram_req ram_req;
    edbw_pkg::t_byte    ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_enable <= 1'b1;
            r_cfg.write_all    <= 1'b0;
            r_cfg.base_address <= '0;
        end else if (i_cfg_we) begin
            case (edbw_pkg::t_cfg_reg'(i_cfg_idx))
                edbw_pkg::CFG_CHECK_ENABLE: r_cfg.check_enable <= i_cfg_data[0];
                edbw_pkg::CFG_WRITE_ALL:    r_cfg.write_all    <= i_cfg_data[0];
                edbw_pkg::CFG_BASE_ADDRESS: begin
                    r_cfg.base_address <= i_cfg_data[edbw_pkg::BASE_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    edbw_shadow_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    edbw_flush_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_loc           (i_loc),
        .i_dat           (i_dat),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_write_valid   (o_write_valid),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_last          (o_last),
        .o_ram_req       (ram_req),
        .i_ram_rdata     (ram_rdata)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while a previous one still in progress");

    a_ack_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_write_valid)
            |-> (o_last && (o_write_address == '0) && (o_write_data == '0)))
        else $error("acknowledge not final or carries payload");

    a_addr_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_write_valid)
            |-> ((o_write_address - edbw_pkg::ADDR_W'(r_cfg.base_address))
                 < edbw_pkg::ADDR_W'(edbw_pkg::BUFFER_BYTES)))
        else $error("write address outside the buffer image");

endmodule

`default_nettype wire

/* hw/rtl/edbw_shadow_ram.sv */
`default_nettype none

module edbw_shadow_ram (
    input  wire                 i_clk,
    input  edbw_pkg::t_ram_req  i_req,
    output edbw_pkg::t_byte     o_rdata
);

    edbw_pkg::t_byte r_mem [edbw_pkg::BUFFER_BYTES];
    edbw_pkg::t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/edbw_flush_ctrl.sv */
`default_nettype none

module edbw_flush_ctrl (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  edbw_pkg::t_cfg                 i_cfg,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire                            i_func,
    input  wire [edbw_pkg::LOC_W-1:0]      i_loc,
    input  wire [7:0]                      i_dat,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic                           o_write_valid,
    output logic [edbw_pkg::ADDR_W-1:0]    o_write_address,
    output logic [7:0]                     o_write_data,
    output logic                           o_last,
    output edbw_pkg::t_ram_req             o_ram_req,
    input  edbw_pkg::t_byte                i_ram_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SAVE,
        S_CHECK,
        S_SCAN,
        S_DATA
    } t_state;

    localparam edbw_pkg::t_idx LAST_IDX = edbw_pkg::IDX_W'(edbw_pkg::BUFFER_BYTES - 1);
    localparam edbw_pkg::t_idx CHK_IDX  = edbw_pkg::IDX_W'(edbw_pkg::CHECK_INDEX);

    t_state                          r_state;
    edbw_pkg::t_idx                  r_idx;
    logic [edbw_pkg::CNT_W-1:0]      r_cnt;
    logic                            r_pending;
    logic                            r_changed;
    edbw_pkg::t_byte                 r_sum;
    edbw_pkg::t_idx                  r_loc;
    edbw_pkg::t_byte                 r_dat;
    logic                            r_save_ok;
    logic [edbw_pkg::BUFFER_BYTES-1:0] r_dirty;
    logic [edbw_pkg::BUFFER_BYTES-1:0] r_written;
    logic                            r_rd_zero;
    logic                            r_ov;
    logic                            r_wv;
    logic [edbw_pkg::ADDR_W-1:0]     r_wa;
    edbw_pkg::t_byte                 r_wd;
    logic                            r_last;

    logic            accept;
    logic            loc_ok;
    logic            out_free;
    logic            sel;
    logic            can_emit;
    logic            more_above;
    logic            last_wr;
    logic            n_pending;
    edbw_pkg::t_byte old_byte;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign loc_ok   = 32'(i_loc) < edbw_pkg::BUFFER_BYTES;
    assign out_free = !r_ov || !i_out_stall;
    assign sel      = i_cfg.write_all || r_dirty[r_idx];
    assign can_emit = 32'(r_cnt) < edbw_pkg::MAX_RESULTS;
    assign old_byte = r_rd_zero ? 8'd0 : i_ram_rdata;
    assign n_pending = r_pending || (sel && !can_emit && r_dirty[r_idx]);

    always_comb begin
        more_above = 1'b0;
        for (int j = 0; j < edbw_pkg::BUFFER_BYTES; j++) begin
            if ((32'(j) > 32'(r_idx)) && (i_cfg.write_all || r_dirty[j])) begin
                more_above = 1'b1;
            end
        end
    end

    // last write of a flush: nothing selected above, or the cap is reached
    assign last_wr = !(more_above && ((32'(r_cnt) + 1) < edbw_pkg::MAX_RESULTS));

    always_comb begin
        o_ram_req = '0;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_func == edbw_pkg::FUNC_SAVE) && loc_ok) begin
                    o_ram_req.rd_en = 1'b1;
                    o_ram_req.addr  = edbw_pkg::IDX_W'(i_loc);
                end
            end
            S_SAVE: begin
                if (out_free && r_save_ok) begin
                    o_ram_req.wr_en = 1'b1;
                    o_ram_req.addr  = r_loc;
                    o_ram_req.wdata = r_dat;
                end
            end
            S_CHECK: begin
                o_ram_req.wr_en = 1'b1;
                o_ram_req.addr  = CHK_IDX;
                o_ram_req.wdata = ~r_sum;
            end
            S_SCAN: begin
                if (sel && can_emit) begin
                    o_ram_req.rd_en = 1'b1;
                    o_ram_req.addr  = r_idx;
                end
            end
            default: begin
                o_ram_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_cnt     <= '0;
            r_pending <= 1'b0;
            r_changed <= 1'b0;
            r_sum     <= '0;
            r_save_ok <= 1'b0;
            r_dirty   <= '0;
            r_written <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (o_ram_req.rd_en) begin
                r_rd_zero <= !r_written[o_ram_req.addr];
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_loc <= edbw_pkg::IDX_W'(i_loc);
                        r_dat <= i_dat;
                        r_idx <= '0;
                        r_cnt <= '0;
                        r_pending <= 1'b0;
                        if (i_func == edbw_pkg::FUNC_SAVE) begin
                            r_save_ok <= loc_ok;
                            r_state   <= S_SAVE;
                        end else if (!r_changed && !i_cfg.write_all) begin
                            r_save_ok <= 1'b0;
                            r_state   <= S_SAVE;
                        end else if (i_cfg.check_enable && edbw_pkg::HAS_CHECK) begin
                            r_state <= S_CHECK;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                // acknowledge; for a save, also the write half of read-modify-write
                S_SAVE: begin
                    if (out_free) begin
                        if (r_save_ok) begin
                            r_dirty[r_loc]   <= 1'b1;
                            r_written[r_loc] <= 1'b1;
                            r_changed        <= 1'b1;
                            if (32'(r_loc) < edbw_pkg::CHECK_INDEX) begin
                                r_sum <= r_sum - old_byte + r_dat;
                            end
                        end
                        r_ov    <= 1'b1;
                        r_wv    <= 1'b0;
                        r_wa    <= '0;
                        r_wd    <= '0;
                        r_last  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_CHECK: begin
                    r_dirty[CHK_IDX]   <= 1'b1;
                    r_written[CHK_IDX] <= 1'b1;
                    r_state            <= S_SCAN;
                end
                S_SCAN: begin
                    if (sel && can_emit) begin
                        r_state <= S_DATA;
                    end else begin
                        r_pending <= n_pending;
                        if (r_idx == LAST_IDX) begin
                            r_changed <= n_pending;
                            if (r_cnt == '0) begin
                                r_save_ok <= 1'b0;
                                r_state   <= S_SAVE;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_DATA: begin
                    if (out_free) begin
                        r_ov   <= 1'b1;
                        r_wv   <= 1'b1;
                        r_wa   <= edbw_pkg::ADDR_W'(i_cfg.base_address)
                                  + edbw_pkg::ADDR_W'(r_idx);
                        r_wd   <= old_byte;
                        r_last <= last_wr;
                        r_dirty[r_idx] <= 1'b0;
                        r_cnt  <= r_cnt + 1'b1;
                        if (r_idx == LAST_IDX) begin
                            r_changed <= r_pending;
                            r_state   <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_ov;
    assign o_write_valid   = r_wv;
    assign o_write_address = r_wa;
    assign o_write_data    = r_wd;
    assign o_last          = r_last;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`default_nettype none

module tb_top;

    typedef struct packed {
        logic                        wr_valid;
        logic [edbw_pkg::ADDR_W-1:0] addr;
        edbw_pkg::t_byte             data;
        logic                        last;
    } t_eeprom_write;

    typedef enum bit {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind                       kind;
        edbw_pkg::t_func                 func;
        logic [edbw_pkg::LOC_W-1:0]      loc;
        edbw_pkg::t_byte                 dat;
        edbw_pkg::t_cfg_reg              reg_sel;
        logic [edbw_pkg::CFG_DATA_W-1:0] reg_val;
        bit                              typed;
        t_eeprom_write                   exp_res;
    } t_row;

    localparam t_eeprom_write ACK  = '{1'b0, '0, '0, 1'b1};
    localparam t_eeprom_write NONE = '0;
    localparam int DIR_ROWS = 25;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [edbw_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [edbw_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic                            i_func;
    logic [edbw_pkg::LOC_W-1:0]      i_loc;
    logic [7:0]                      i_dat;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic                            o_write_valid;
    logic [edbw_pkg::ADDR_W-1:0]     o_write_address;
    logic [7:0]                      o_write_data;
    logic                            o_last;

    // shadow image as the block should hold it
    edbw_pkg::t_byte             shadow_img [edbw_pkg::BUFFER_BYTES];
    bit                          dirty      [edbw_pkg::BUFFER_BYTES];
    bit                          changed;
    bit                          chk_en;
    bit                          wr_all;
    logic [edbw_pkg::BASE_W-1:0] base;

    t_eeprom_write step_out  [$];
    t_eeprom_write due_writes[$];

    int  mism_cnt = 0;
    int  snd_idle_pct;
    int  rcv_idle_pct;
    bit  long_hold_go = 1'b0;
    int  hold_left = 0;

    t_row dir_tab [DIR_ROWS] = '{
        '{ROW_REQ, edbw_pkg::FUNC_FLUSH, 5'd0,  8'h00, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b1, ACK},
        '{ROW_REQ, edbw_pkg::FUNC_SAVE,  5'd0,  8'hFF, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b1, ACK},
        '{ROW_REQ, edbw_pkg::FUNC_SAVE,  5'd31, 8'h00, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b1, ACK},
        '{ROW_REQ, edbw_pkg::FUNC_SAVE,  5'd30, 8'hA5, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b1, ACK},
        '{ROW_REQ, edbw_pkg::FUNC_SAVE,  5'd16, 8'h80, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b1, ACK},
        '{ROW_REQ, edbw_pkg::FUNC_FLUSH, 5'd0,  8'h00, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b0, NONE},
        '{ROW_REQ, edbw_pkg::FUNC_FLUSH, 5'd31, 8'hFF, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b1, ACK},
        '{ROW_CFG, edbw_pkg::FUNC_SAVE,  5'd0,  8'h00, edbw_pkg::CFG_WRITE_ALL,    12'd1, 1'b0, NONE},
        '{ROW_CFG, edbw_pkg::FUNC_SAVE,  5'd0,  8'h00, edbw_pkg::CFG_BASE_ADDRESS, 12'hFFF,
          1'b0, NONE},
        '{ROW_CFG, edbw_pkg::FUNC_SAVE,  5'd0,  8'h00, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b0, NONE},
        '{ROW_REQ, edbw_pkg::FUNC_FLUSH, 5'd0,  8'h00, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b0, NONE},
        '{ROW_REQ, edbw_pkg::FUNC_SAVE,  5'd1,  8'h7F, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b1, ACK},
        '{ROW_REQ, edbw_pkg::FUNC_FLUSH, 5'd0,  8'h00, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b0, NONE},
        '{ROW_CFG, edbw_pkg::FUNC_SAVE,  5'd0,  8'h00, edbw_pkg::CFG_WRITE_ALL,    12'd0, 1'b0, NONE},
        '{ROW_CFG, edbw_pkg::FUNC_SAVE,  5'd0,  8'h00, edbw_pkg::CFG_BASE_ADDRESS, 12'h800,
          1'b0, NONE},
        '{ROW_REQ, edbw_pkg::FUNC_SAVE,  5'd31, 8'h3C, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b1, ACK},
        '{ROW_REQ, edbw_pkg::FUNC_FLUSH, 5'd0,  8'h00, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b0, NONE},
        '{ROW_REQ, edbw_pkg::FUNC_FLUSH, 5'd0,  8'h00, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b1, ACK},
        '{ROW_CFG, edbw_pkg::FUNC_SAVE,  5'd0,  8'h00, edbw_pkg::CFG_CHECK_ENABLE, 12'd1, 1'b0, NONE},
        '{ROW_CFG, edbw_pkg::FUNC_SAVE,  5'd0,  8'h00, edbw_pkg::CFG_BASE_ADDRESS, 12'd0, 1'b0, NONE},
        '{ROW_REQ, edbw_pkg::FUNC_SAVE,  5'd31, 8'hFF, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b1, ACK},
        '{ROW_REQ, edbw_pkg::FUNC_SAVE,  5'd2,  8'h01, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b1, ACK},
        '{ROW_REQ, edbw_pkg::FUNC_FLUSH, 5'd0,  8'h00, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b0, NONE},
        '{ROW_REQ, edbw_pkg::FUNC_SAVE,  5'd15, 8'h55, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b1, ACK},
        '{ROW_REQ, edbw_pkg::FUNC_FLUSH, 5'd0,  8'h00, edbw_pkg::CFG_CHECK_ENABLE, 12'd0, 1'b0, NONE}
    };

    eeprom_dirty_byte_write_back u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_loc           (i_loc),
        .i_dat           (i_dat),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_write_valid   (o_write_valid),
        .o_write_address (o_write_address),
        .o_write_data    (o_write_data),
        .o_last          (o_last)
    );

    always #10 i_clk = ~i_clk;

    // Writes (or the acknowledge) that one request causes, left in step_out.
    function automatic void compute_writes(input edbw_pkg::t_func f,
                                           input logic [edbw_pkg::LOC_W-1:0] loc,
                                           input edbw_pkg::t_byte dat);
        edbw_pkg::t_byte sum;
        t_eeprom_write   w;
        int              n;
        int              i;
        bit              more;
        step_out.delete();
        n    = 0;
        more = 1'b0;
        if (f == edbw_pkg::FUNC_SAVE) begin
            if (int'(loc) < edbw_pkg::BUFFER_BYTES) begin
                shadow_img[loc] = dat;
                dirty[loc]      = 1'b1;
                changed         = 1'b1;
            end
            step_out.push_back(ACK);
            return;
        end
        if (!changed && !wr_all) begin
            step_out.push_back(ACK);
            return;
        end
        if (chk_en && edbw_pkg::HAS_CHECK) begin
            sum = '0;
            for (i = 0; i < edbw_pkg::CHECK_INDEX && i < edbw_pkg::BUFFER_BYTES; i++)
                sum = sum + shadow_img[i];
            shadow_img[edbw_pkg::CHECK_INDEX % edbw_pkg::BUFFER_BYTES] = ~sum;
            dirty[edbw_pkg::CHECK_INDEX % edbw_pkg::BUFFER_BYTES]      = 1'b1;
        end
        for (i = 0; i < edbw_pkg::BUFFER_BYTES; i++) begin
            if (!(wr_all || dirty[i]))
                continue;
            // past the per-flush limit: dirty bytes wait for the next flush
            if (n >= edbw_pkg::MAX_RESULTS) begin
                if (dirty[i])
                    more = 1'b1;
                continue;
            end
            w.wr_valid = 1'b1;
            w.addr     = edbw_pkg::ADDR_W'(base) + edbw_pkg::ADDR_W'(i);
            w.data     = shadow_img[i];
            w.last     = 1'b0;
            step_out.push_back(w);
            dirty[i] = 1'b0;
            n++;
        end
        changed = more;
        if (n == 0) begin
            step_out.push_back(ACK);
        end else begin
            w      = step_out.pop_back();
            w.last = 1'b1;
            step_out.push_back(w);
        end
    endfunction

    // Called just after a falling edge, returns just after a falling edge.
    task automatic send_request(input edbw_pkg::t_func f,
                                input logic [edbw_pkg::LOC_W-1:0] loc,
                                input edbw_pkg::t_byte dat,
                                input bit typed, input t_eeprom_write typed_res);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_loc      <= loc;
        i_dat      <= dat;
        do
            @(posedge i_clk);
        while (o_in_stall);
        compute_writes(f, loc, dat);
        if (typed) begin
            due_writes.push_back(typed_res);
        end else begin
            foreach (step_out[j])
                due_writes.push_back(step_out[j]);
        end
        @(negedge i_clk);
    endtask

    // the block may still scan the buffer after its last write, so wait for idle too
    task automatic drain_writes();
        i_in_valid <= 1'b0;
        while (due_writes.size() != 0 || o_in_stall)
            @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input edbw_pkg::t_cfg_reg sel,
                             input logic [edbw_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sel;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (sel)
            edbw_pkg::CFG_CHECK_ENABLE: chk_en = val[0];
            edbw_pkg::CFG_WRITE_ALL:    wr_all = val[0];
            edbw_pkg::CFG_BASE_ADDRESS: base   = val[edbw_pkg::BASE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic report_fail(input string what, input t_eeprom_write exp_w,
                               input t_eeprom_write got);
        if (mism_cnt < 10)
            $display("%s: exp v=%0b a=%h d=%h l=%0b  got v=%0b a=%h d=%h l=%0b", what,
                     exp_w.wr_valid, exp_w.addr, exp_w.data, exp_w.last,
                     got.wr_valid, got.addr, got.data, got.last);
        mism_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_eeprom_write got;
        t_eeprom_write exp_w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_write_valid, o_write_address, o_write_data, o_last};
            if (due_writes.size() == 0) begin
                report_fail("unexpected write", NONE, got);
            end else begin
                exp_w = due_writes.pop_front();
                if (got.wr_valid !== exp_w.wr_valid || got.addr !== exp_w.addr ||
                    got.data !== exp_w.data || got.last !== exp_w.last)
                    report_fail("write mismatch", exp_w, got);
            end
        end
    end

    // Receiver side: random stall, plus one long hold-off on request.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_go) begin
                long_hold_go = 1'b0;
                hold_left    = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
            end
        end
    end

    initial begin
        int                              mode;
        int                              sub;
        int                              k;
        edbw_pkg::t_func                 f;
        logic [edbw_pkg::CFG_DATA_W-1:0] base_val;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = edbw_pkg::CFG_CHECK_ENABLE;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_func       = edbw_pkg::FUNC_SAVE;
        i_loc        = '0;
        i_dat        = '0;
        snd_idle_pct = 18;
        rcv_idle_pct = 66;
        foreach (shadow_img[j]) begin
            shadow_img[j] = '0;
            dirty[j]      = 1'b0;
        end
        changed = 1'b0;
        chk_en  = 1'b1;
        wr_all  = 1'b0;
        base    = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[r]) begin
            if (dir_tab[r].kind == ROW_CFG) begin
                drain_writes();
                write_reg(dir_tab[r].reg_sel, dir_tab[r].reg_val);
            end else begin
                send_request(dir_tab[r].func, dir_tab[r].loc, dir_tab[r].dat,
                             dir_tab[r].typed, dir_tab[r].exp_res);
            end
        end

        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin snd_idle_pct = 18; rcv_idle_pct = 66; end
                1: begin snd_idle_pct = 66; rcv_idle_pct = 18; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            for (sub = 0; sub < 3; sub++) begin
                drain_writes();
                case ($urandom_range(3))
                    0: base_val = '0;
                    1: base_val = 12'hFFF;
                    default: base_val = edbw_pkg::CFG_DATA_W'($urandom_range(4095));
                endcase
                write_reg(edbw_pkg::CFG_CHECK_ENABLE,
                          edbw_pkg::CFG_DATA_W'($urandom_range(1)));
                write_reg(edbw_pkg::CFG_WRITE_ALL,
                          (sub == 2) ? edbw_pkg::CFG_DATA_W'($urandom_range(1)) : '0);
                write_reg(edbw_pkg::CFG_BASE_ADDRESS, base_val);
                // output held off while requests keep coming, so the input backs up
                if (mode == 2 && sub == 0)
                    long_hold_go = 1'b1;
                for (k = 0; k < 30; k++) begin
                    f = ($urandom_range(99) < 15) ? edbw_pkg::FUNC_FLUSH : edbw_pkg::FUNC_SAVE;
                    send_request(f, edbw_pkg::LOC_W'($urandom_range(31)),
                                 edbw_pkg::t_byte'($urandom), 1'b0, NONE);
                end
            end
        end

        drain_writes();
        repeat (70) @(posedge i_clk);
        mism_cnt += due_writes.size();
        if (mism_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
